/* rtl/core/ray_quad_intersection_test_top_assert.svh */
// ----------------------------------------------------------------------------
// Ray / quad intersection test assertion macros
// Concurrent checks on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RAY_QUAD_INTERSECTION_TEST_TOP_ASSERT_SVH
`define RAY_QUAD_INTERSECTION_TEST_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication
`define RQIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define RQIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RQIT_ASSERT_IMP(lbl, ante, cons, msg)
`define RQIT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/rqit_pkg.sv */
// ----------------------------------------------------------------------------
// Ray / quad intersection test package
// Result codes and configuration register indexes.
// ----------------------------------------------------------------------------
package rqit_pkg;

  typedef logic [1:0] tri_sel_t;
  typedef logic [0:0] cfg_idx_t;

  localparam tri_sel_t TRI_NONE   = 2'd0;
  localparam tri_sel_t TRI_FIRST  = 2'd1;
  localparam tri_sel_t TRI_SECOND = 2'd2;
  localparam tri_sel_t TRI_UNUSED = 2'd3;

  localparam cfg_idx_t REG_DET_THR  = 1'b0;
  localparam cfg_idx_t REG_DIST_THR = 1'b1;

  localparam int CFG_WIDTH      = 32;
  localparam int DIST_THR_WIDTH = 31;

endpackage

/* rtl/core/ray_quad_intersection_test_top.sv */
// ----------------------------------------------------------------------------
// Ray / axis-aligned quad intersection test
// Moller-Trumbore on the two triangles of the quad, division free, exact.
// ----------------------------------------------------------------------------
// Takes one word per cycle and returns one result word per input word, in
// order, after four arithmetic stages and an output register. The whole
// pipeline advances together; it holds only while a result waits on out_stall.
// The stage count is set by the chain of products: offset times direction,
// then extent times that cross term. The user must write thresholds through
// the cfg port while the pipeline is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "ray_quad_intersection_test_top_assert.svh"

module ray_quad_intersection_test_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  rqit_pkg::cfg_idx_t                cfg_index,
  input  logic [rqit_pkg::CFG_WIDTH-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     in_ray_origin_x,
  input  logic signed [COORD_WIDTH-1:0]     in_ray_origin_y,
  input  logic signed [COORD_WIDTH-1:0]     in_ray_origin_z,
  input  logic signed [COORD_WIDTH-1:0]     in_ray_dir_x,
  input  logic signed [COORD_WIDTH-1:0]     in_ray_dir_y,
  input  logic signed [COORD_WIDTH-1:0]     in_ray_dir_z,
  input  logic signed [COORD_WIDTH-1:0]     in_quad_center_x,
  input  logic signed [COORD_WIDTH-1:0]     in_quad_center_y,
  input  logic signed [COORD_WIDTH-1:0]     in_quad_plane_z,
  input  logic        [COORD_WIDTH-2:0]     in_quad_width,
  input  logic        [COORD_WIDTH-2:0]     in_quad_height,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output rqit_pkg::tri_sel_t                out_hit_triangle
);
  import rqit_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int SXW  = CW + 3;          // doubled x/y offset
  localparam int SZW  = CW + 2;          // doubled z offset
  localparam int DW   = CW + 1;          // |dz| and sign-corrected dx, dy
  localparam int UW   = CW - 1;          // quad extents
  localparam int PW   = 2 * CW + 5;      // cross terms P, Q
  localparam int MW   = DW + UW;         // |dz| * extent
  localparam int AW   = 2 * UW;          // area w*h
  localparam int DTW  = DW + DIST_THR_WIDTH;
  localparam int LW   = CW + 1;          // low split of P, Q
  localparam int HW   = CW;              // high split of P, Q
  localparam int XW   = 3 * CW + 1;
  localparam int DXW  = DW + 32;
  localparam int AXW  = AW + 32;
  localparam int TW   = ((SZW + FRAC_BITS) > (DTW + 1) ? (SZW + FRAC_BITS) : (DTW + 1)) + 1;

  // Configuration
  logic [CFG_WIDTH-1:0]      det_thr_r;
  logic [DIST_THR_WIDTH-1:0] dist_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_thr_r  <= CFG_WIDTH'(1);
      dist_thr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DET_THR:  det_thr_r  <= cfg_wdata;
        REG_DIST_THR: dist_thr_r <= cfg_wdata[DIST_THR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves together
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // ---------------- Stage 1: offsets and sign correction ----------------
  logic signed [SXW-1:0] sx_nxt, sy_nxt;
  logic signed [SZW-1:0] sz_nxt, nz_nxt;
  logic signed [DW-1:0]  dz_e, dx_e, dy_e, dxf_nxt, dyf_nxt, dabs_s;
  logic        [DW-1:0]  d_nxt;
  logic                  neg;

  always_comb begin
    sx_nxt = ($signed({{3{in_ray_origin_x[CW-1]}}, in_ray_origin_x}) <<< 1)
           - ($signed({{3{in_quad_center_x[CW-1]}}, in_quad_center_x}) <<< 1)
           + $signed({4'b0, in_quad_width});
    sy_nxt = ($signed({{3{in_ray_origin_y[CW-1]}}, in_ray_origin_y}) <<< 1)
           - ($signed({{3{in_quad_center_y[CW-1]}}, in_quad_center_y}) <<< 1)
           + $signed({4'b0, in_quad_height});
    sz_nxt = ($signed({{2{in_ray_origin_z[CW-1]}}, in_ray_origin_z}) <<< 1)
           - ($signed({{2{in_quad_plane_z[CW-1]}}, in_quad_plane_z}) <<< 1);
    neg    = in_ray_dir_z[CW-1];
    dz_e   = $signed({in_ray_dir_z[CW-1], in_ray_dir_z});
    dx_e   = $signed({in_ray_dir_x[CW-1], in_ray_dir_x});
    dy_e   = $signed({in_ray_dir_y[CW-1], in_ray_dir_y});
    // flip the system so the determinant is never negative
    dabs_s  = neg ? -dz_e : dz_e;
    d_nxt   = dabs_s;
    dxf_nxt = neg ? -dx_e : dx_e;
    dyf_nxt = neg ? -dy_e : dy_e;
    nz_nxt  = neg ? sz_nxt : -sz_nxt;
  end

  logic                  s1_v_r;
  logic signed [SXW-1:0] s1_sx_r, s1_sy_r;
  logic signed [SZW-1:0] s1_sz_r, s1_nz_r;
  logic        [DW-1:0]  s1_d_r;
  logic signed [DW-1:0]  s1_dxf_r, s1_dyf_r;
  logic        [UW-1:0]  s1_w_r, s1_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sx_r  <= sx_nxt;
      s1_sy_r  <= sy_nxt;
      s1_sz_r  <= sz_nxt;
      s1_nz_r  <= nz_nxt;
      s1_d_r   <= d_nxt;
      s1_dxf_r <= dxf_nxt;
      s1_dyf_r <= dyf_nxt;
      s1_w_r   <= in_quad_width;
      s1_h_r   <= in_quad_height;
    end
  end

  // ---------------- Stage 2: first products ----------------
  logic signed [PW-1:0]  sxd_nxt, syd_nxt, szdx_nxt, szdy_nxt;
  logic        [MW-1:0]  dw_nxt, dh_nxt;
  logic        [AW-1:0]  a_nxt;
  logic        [DTW-1:0] dt_nxt;

  always_comb begin
    sxd_nxt  = PW'(s1_sx_r) * PW'($signed({1'b0, s1_d_r}));
    syd_nxt  = PW'(s1_sy_r) * PW'($signed({1'b0, s1_d_r}));
    szdx_nxt = PW'(s1_sz_r) * PW'(s1_dxf_r);
    szdy_nxt = PW'(s1_sz_r) * PW'(s1_dyf_r);
    dw_nxt   = MW'(s1_d_r) * MW'(s1_w_r);
    dh_nxt   = MW'(s1_d_r) * MW'(s1_h_r);
    a_nxt    = AW'(s1_w_r) * AW'(s1_h_r);
    dt_nxt   = DTW'(s1_d_r) * DTW'(dist_thr_r);
  end

  logic                  s2_v_r;
  logic signed [PW-1:0]  s2_sxd_r, s2_syd_r, s2_szdx_r, s2_szdy_r;
  logic        [MW-1:0]  s2_dw_r, s2_dh_r;
  logic        [AW-1:0]  s2_a_r;
  logic        [DTW-1:0] s2_dt_r;
  logic        [DW-1:0]  s2_d_r;
  logic signed [SZW-1:0] s2_nz_r;
  logic        [UW-1:0]  s2_w_r, s2_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sxd_r  <= sxd_nxt;
      s2_syd_r  <= syd_nxt;
      s2_szdx_r <= szdx_nxt;
      s2_szdy_r <= szdy_nxt;
      s2_dw_r   <= dw_nxt;
      s2_dh_r   <= dh_nxt;
      s2_a_r    <= a_nxt;
      s2_dt_r   <= dt_nxt;
      s2_d_r    <= s1_d_r;
      s2_nz_r   <= s1_nz_r;
      s2_w_r    <= s1_w_r;
      s2_h_r    <= s1_h_r;
    end
  end

  // ---------------- Stage 3: cross terms and range checks ----------------
  logic signed [PW-1:0]  p_s, q_s;
  logic                  p_ok_nxt, q_ok_nxt, t_ok_nxt;
  logic signed [TW-1:0]  t_lhs, t_rhs;
  logic        [DXW-1:0] d_ext;
  logic        [AXW-1:0] a_ext;
  logic                  det_nz_nxt, det_big_nxt;
  logic        [63:0]    dprod_nxt;

  always_comb begin
    p_s = s2_sxd_r - s2_szdx_r;
    q_s = s2_syd_r - s2_szdy_r;
    // u, v inside [0, 2det] once the extents are divided out
    p_ok_nxt = !p_s[PW-1] &&
               (p_s <= $signed({{(PW-MW-1){1'b0}}, s2_dw_r, 1'b0}));
    q_ok_nxt = !q_s[PW-1] &&
               (q_s <= $signed({{(PW-MW-1){1'b0}}, s2_dh_r, 1'b0}));
    t_lhs = $signed({{(TW-SZW){s2_nz_r[SZW-1]}}, s2_nz_r}) <<< FRAC_BITS;
    t_rhs = $signed({{(TW-DTW-1){1'b0}}, s2_dt_r, 1'b0});
    t_ok_nxt = t_lhs > t_rhs;
    d_ext = {32'b0, s2_d_r};
    a_ext = {32'b0, s2_a_r};
    det_nz_nxt  = (s2_d_r != '0) && (s2_a_r != '0);
    det_big_nxt = (|d_ext[DXW-1:32]) || (|a_ext[AXW-1:32]);
    dprod_nxt   = 64'(d_ext[31:0]) * 64'(a_ext[31:0]);
  end

  logic                  s3_v_r;
  logic [LW+HW-1:0]      s3_p_r, s3_q_r;
  logic                  s3_p_ok_r, s3_q_ok_r, s3_t_ok_r, s3_det_nz_r, s3_det_big_r;
  logic [63:0]           s3_dprod_r;
  logic [UW-1:0]         s3_w_r, s3_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_p_r       <= p_s[LW+HW-1:0];
      s3_q_r       <= q_s[LW+HW-1:0];
      s3_p_ok_r    <= p_ok_nxt;
      s3_q_ok_r    <= q_ok_nxt;
      s3_t_ok_r    <= t_ok_nxt;
      s3_det_nz_r  <= det_nz_nxt;
      s3_det_big_r <= det_big_nxt;
      s3_dprod_r   <= dprod_nxt;
      s3_w_r       <= s2_w_r;
      s3_h_r       <= s2_h_r;
    end
  end

  // ---------------- Stage 4: split products h*P, w*Q ----------------
  logic [UW+LW-1:0] hplo_nxt, wqlo_nxt;
  logic [UW+HW-1:0] hphi_nxt, wqhi_nxt;
  logic             ok_nxt;

  always_comb begin
    hplo_nxt = (UW+LW)'(s3_h_r) * (UW+LW)'(s3_p_r[LW-1:0]);
    hphi_nxt = (UW+HW)'(s3_h_r) * (UW+HW)'(s3_p_r[LW+HW-1:LW]);
    wqlo_nxt = (UW+LW)'(s3_w_r) * (UW+LW)'(s3_q_r[LW-1:0]);
    wqhi_nxt = (UW+HW)'(s3_w_r) * (UW+HW)'(s3_q_r[LW+HW-1:LW]);
    ok_nxt   = s3_det_nz_r &&
               (s3_det_big_r || (s3_dprod_r >= {32'b0, det_thr_r})) &&
               s3_p_ok_r && s3_q_ok_r && s3_t_ok_r;
  end

  logic             s4_v_r, s4_ok_r;
  logic [UW+LW-1:0] s4_hplo_r, s4_wqlo_r;
  logic [UW+HW-1:0] s4_hphi_r, s4_wqhi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ok_r   <= ok_nxt;
      s4_hplo_r <= hplo_nxt;
      s4_hphi_r <= hphi_nxt;
      s4_wqlo_r <= wqlo_nxt;
      s4_wqhi_r <= wqhi_nxt;
    end
  end

  // ---------------- Stage 5: pick the triangle ----------------
  logic [XW-1:0] x_s, y_s;
  tri_sel_t      tri_nxt;

  always_comb begin
    x_s = XW'({s4_hphi_r, {LW{1'b0}}}) + XW'(s4_hplo_r);
    y_s = XW'({s4_wqhi_r, {LW{1'b0}}}) + XW'(s4_wqlo_r);
    if (!s4_ok_r) begin
      tri_nxt = TRI_NONE;
    end else if (x_s <= y_s) begin
      tri_nxt = TRI_FIRST;
    end else begin
      tri_nxt = TRI_SECOND;
    end
  end

  tri_sel_t out_tri_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tri_r <= tri_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit_triangle = out_tri_r;
  assign out_hit          = (out_tri_r != TRI_NONE);

  // ---------------- Checks ----------------
  `RQIT_ASSERT_IMP(a_tri_code, out_valid_r, out_tri_r != TRI_UNUSED, "bad triangle code")
  `RQIT_ASSERT_NXT(a_pipe_hold, out_valid_r && out_stall, $stable({s1_v_r, s2_v_r, s3_v_r, s4_v_r}), "pipeline moved under stall")
  `RQIT_ASSERT_IMP(a_in_stall, !out_valid_r, !in_stall, "stalled with empty output")

endmodule
